// ----- design/lr_pkg.sv -----
// Shared types and constants for the line rasterizer.
// No dependencies; imported by line_rasterizer and tb_line_rasterizer.
package lr_pkg;

   // Default coordinate width and the canvas register's width and reset value
   localparam int COORD_BITS_DEF = 12;
   localparam int CANVAS_BITS    = 11;
   localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 11'd800;
   localparam int COLOR_BITS     = 2;

   // Item kinds carried in req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Walk modes: span modes cover min..max inclusive, step modes run Bresenham
   typedef enum logic [1:0] {
      MODE_X_SPAN = 2'd0,
      MODE_Y_SPAN = 2'd1,
      MODE_X_STEP = 2'd2,
      MODE_Y_STEP = 2'd3
   } line_mode_type;

endpackage

// ----- design/line_rasterizer.sv -----
// Line rasterizer top level: endpoint load, per-tick pixel walk, result skid stage.
// Depends on lr_pkg for modes, item kinds and register constants.
//
//   channel  direction  handshake               contents
//   req_     in         tvalid/tready           tuser = kind, tdata = endpoints and color
//   rsp_     out        tvalid/tready/tlast     tdata = pixel, visible flag, color
//   csr_     in         valid/ready             data = canvas size
//
// One item is taken per clock while req_tready is high. A tick item that emits a
// pixel goes to the output register, or to the skid when rsp_ stalls. The whole
// step (walk update and visibility compare) sits between the input handshake and
// the result register. A two-deep result stage (output register plus skid) lets
// one more item in while a pixel waits; req_tready drops only when both hold pixels.
// Reset is synchronous; canvas size returns to 800 and no line is active.
module line_rasterizer
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request: tuser = op; tdata = start_x, start_y, end_x, end_y, line_color, zero pad
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_tuser,
   input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // response: tdata = pixel_x, pixel_y, visible, pixel_color, zero pad; tlast = last
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       rsp_tlast,
   output logic [((2*COORD_BITS+1+COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   // canvas size register write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CANVAS_BITS-1:0]     csr_data
);

   localparam int C       = COORD_BITS;
   localparam int ERR_W   = COORD_BITS + 2;
   localparam int RSP_USE = 2*COORD_BITS + 1 + COLOR_BITS;
   localparam int RSP_W   = ((RSP_USE + 7) / 8) * 8;
   localparam int CMP_W   = ((COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS) + 1;

   // Configuration register
   logic [CANVAS_BITS-1:0] canvas_ff;

   // Walk state
   logic                  busy_ff, busy_in;
   line_mode_type         mode_ff, mode_in;
   logic signed [C-1:0]   major_pos_ff, major_pos_in;
   logic signed [C-1:0]   major_stop_ff, major_stop_in;
   logic signed [C-1:0]   minor_pos_ff, minor_pos_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [C-1:0]          major_delta_ff, major_delta_in;
   logic [C-1:0]          minor_delta_ff, minor_delta_in;
   logic                  major_up_ff, major_up_in;
   logic                  minor_up_ff, minor_up_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   // Result stage
   logic             out_valid_ff, out_valid_in;
   logic [RSP_W-1:0] out_data_ff, out_data_in;
   logic             out_last_ff, out_last_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [RSP_W-1:0] skid_data_ff, skid_data_in;
   logic             skid_last_ff, skid_last_in;

   // Unpacked request fields
   logic signed [C-1:0]   x1, y1, x2, y2;
   logic [COLOR_BITS-1:0] req_color;

   // Load datapath
   logic signed [C:0] diff_x, diff_y;
   logic [C-1:0]      dx, dy;

   // Tick datapath
   logic                  req_fire, produce, step_mode;
   logic signed [C-1:0]   px, py, major_next, minor_next;
   logic                  pix_last, pix_vis;
   logic signed [CMP_W-1:0] px_ext, py_ext, canvas_ext;
   logic [RSP_W-1:0]      pix_word;

   assign x1        = req_tdata[C-1:0];
   assign y1        = req_tdata[2*C-1:C];
   assign x2        = req_tdata[3*C-1:2*C];
   assign y2        = req_tdata[4*C-1:3*C];
   assign req_color = req_tdata[4*C+COLOR_BITS-1:4*C];

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign produce    = req_fire && (req_tuser == OP_TICK) && busy_ff;

   // Endpoint deltas
   assign diff_x = {x1[C-1], x1} - {x2[C-1], x2};
   assign diff_y = {y1[C-1], y1} - {y2[C-1], y2};
   assign dx     = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
   assign dy     = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];

   // Current pixel, next major position and end test
   assign step_mode  = (mode_ff == MODE_X_STEP) || (mode_ff == MODE_Y_STEP);
   assign px         = (mode_ff == MODE_Y_SPAN || mode_ff == MODE_Y_STEP) ? minor_pos_ff
                                                                          : major_pos_ff;
   assign py         = (mode_ff == MODE_Y_SPAN || mode_ff == MODE_Y_STEP) ? major_pos_ff
                                                                          : minor_pos_ff;
   assign major_next = major_up_ff ? major_pos_ff + C'(1) : major_pos_ff - C'(1);
   assign minor_next = minor_up_ff ? minor_pos_ff + C'(1) : minor_pos_ff - C'(1);
   assign pix_last   = step_mode ? (major_next == major_stop_ff)
                                 : (major_pos_ff == major_stop_ff);

   // Visibility: strictly inside the square canvas
   assign px_ext     = {{(CMP_W-C){px[C-1]}}, px};
   assign py_ext     = {{(CMP_W-C){py[C-1]}}, py};
   assign canvas_ext = {{(CMP_W-CANVAS_BITS){1'b0}}, canvas_ff};
   assign pix_vis    = (px_ext > 0) && (py_ext > 0) &&
                       (px_ext < canvas_ext) && (py_ext < canvas_ext);

   assign pix_word = {{(RSP_W-RSP_USE){1'b0}}, color_ff, pix_vis, py, px};

   // Next walk state: load replaces the line, tick advances one pixel
   always_comb begin
      busy_in        = busy_ff;
      mode_in        = mode_ff;
      major_pos_in   = major_pos_ff;
      major_stop_in  = major_stop_ff;
      minor_pos_in   = minor_pos_ff;
      err_in         = err_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      major_up_in    = major_up_ff;
      minor_up_in    = minor_up_ff;
      color_in       = color_ff;
      if (req_fire && req_tuser == OP_LOAD) begin
         busy_in        = 1'b1;
         color_in       = req_color;
         err_in         = '0;
         minor_delta_in = '0;
         minor_up_in    = 1'b0;
         major_up_in    = 1'b1;
         if (dy == '0) begin
            mode_in        = MODE_X_SPAN;
            major_pos_in   = (x1 < x2) ? x1 : x2;
            major_stop_in  = (x1 < x2) ? x2 : x1;
            minor_pos_in   = y1;
            major_delta_in = dx;
         end else if (dx == '0) begin
            mode_in        = MODE_Y_SPAN;
            major_pos_in   = (y1 < y2) ? y1 : y2;
            major_stop_in  = (y1 < y2) ? y2 : y1;
            minor_pos_in   = x1;
            major_delta_in = dy;
         end else if (dy <= dx) begin
            mode_in        = MODE_X_STEP;
            major_pos_in   = x1;
            major_stop_in  = x2;
            major_up_in    = x2 > x1;
            minor_pos_in   = y1;
            minor_up_in    = y2 > y1;
            major_delta_in = dx;
            minor_delta_in = dy;
            err_in         = $signed({2'b00, dy}) - $signed({2'b00, dx});
         end else begin
            mode_in        = MODE_Y_STEP;
            major_pos_in   = y1;
            major_stop_in  = y2;
            major_up_in    = y2 > y1;
            minor_pos_in   = x1;
            minor_up_in    = x2 > x1;
            major_delta_in = dy;
            minor_delta_in = dx;
            err_in         = $signed({2'b00, dx}) - $signed({2'b00, dy});
         end
      end else if (produce) begin
         if (pix_last) begin
            busy_in = 1'b0;
         end else begin
            if (step_mode) begin
               if (!err_ff[ERR_W-1]) begin
                  minor_pos_in = minor_next;
                  err_in = err_ff - $signed({2'b00, major_delta_ff})
                                  + $signed({2'b00, minor_delta_ff});
               end else begin
                  err_in = err_ff + $signed({2'b00, minor_delta_ff});
               end
            end
            major_pos_in = major_next;
         end
      end
   end

   // Result stage: fill the output register, spill to skid when stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_in   = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_valid_in = 1'b1;
            skid_data_in  = pix_word;
            skid_last_in  = pix_last;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = pix_word;
            out_last_in  = pix_last;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_ff     <= CANVAS_RESET;
         busy_ff       <= 1'b0;
         mode_ff       <= MODE_X_SPAN;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            canvas_ff <= csr_data;
         end
         busy_ff       <= busy_in;
         mode_ff       <= mode_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      major_stop_ff  <= major_stop_in;
      minor_pos_ff   <= minor_pos_in;
      err_ff         <= err_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      major_up_ff    <= major_up_in;
      minor_up_ff    <= minor_up_in;
      color_ff       <= color_in;
      out_data_ff    <= out_data_in;
      out_last_ff    <= out_last_in;
      skid_data_ff   <= skid_data_in;
      skid_last_ff   <= skid_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- verif/tb_line_rasterizer.sv -----
// Self-checking testbench for line_rasterizer: directed and random load/tick items with
// random stalls on both streams; a scoreboard predicts every pixel and checks each one.
// Depends on lr_pkg (item kinds, walk modes, canvas constants) and design/line_rasterizer.sv.
module tb_line_rasterizer;
   import lr_pkg::*;

   localparam int CB    = COORD_BITS_DEF;
   localparam int REQ_W = ((4*CB+COLOR_BITS+7)/8)*8;
   localparam int RSP_W = ((2*CB+1+COLOR_BITS+7)/8)*8;
   localparam int CMIN  = -(1 << (CB-1));
   localparam int CMAX  = (1 << (CB-1)) - 1;

   typedef struct {
      logic signed [CB-1:0]  x;
      logic signed [CB-1:0]  y;
      logic                  vis;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_rec;

   // Bresenham walk predictor plus the queue of pixels still owed by the block
   class raster_scoreboard;
      logic [CANVAS_BITS-1:0] canvas = CANVAS_RESET;
      bit                     active = 0;
      line_mode_type          mode = MODE_X_SPAN;
      logic signed [CB-1:0]   major_pos = '0;
      logic signed [CB-1:0]   major_stop = '0;
      logic signed [CB-1:0]   minor_pos = '0;
      logic signed [13:0]     err = '0;
      logic [CB-1:0]          major_delta = '0;
      logic [CB-1:0]          minor_delta = '0;
      bit                     major_up = 0;
      bit                     minor_up = 0;
      logic [COLOR_BITS-1:0]  held_color = '0;
      pixel_rec               expected_pixels[$];
      int                     errors = 0;

      function void note_canvas(logic [CANVAS_BITS-1:0] v);
         canvas = v;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Returns 1 when the item does something: every load, and a tick that emits
      function bit note_request(logic op, logic [REQ_W-1:0] data);
         int       x1, y1, x2, y2, dx, dy, ipx, ipy;
         logic signed [CB-1:0] nxt;
         bit       y_major, stepped;
         pixel_rec p;
         if (op == OP_LOAD) begin
            x1 = $signed(data[CB-1:0]);
            y1 = $signed(data[2*CB-1:CB]);
            x2 = $signed(data[3*CB-1:2*CB]);
            y2 = $signed(data[4*CB-1:3*CB]);
            dx = (x1 > x2) ? x1 - x2 : x2 - x1;
            dy = (y1 > y2) ? y1 - y2 : y2 - y1;
            held_color  = data[4*CB+COLOR_BITS-1:4*CB];
            active      = 1;
            err         = '0;
            minor_delta = '0;
            minor_up    = 0;
            major_up    = 1;
            if (dy == 0) begin
               mode        = MODE_X_SPAN;
               major_pos   = (x1 < x2) ? x1 : x2;
               major_stop  = (x1 < x2) ? x2 : x1;
               minor_pos   = y1;
               major_delta = dx;
            end else if (dx == 0) begin
               mode        = MODE_Y_SPAN;
               major_pos   = (y1 < y2) ? y1 : y2;
               major_stop  = (y1 < y2) ? y2 : y1;
               minor_pos   = x1;
               major_delta = dy;
            end else if (dy <= dx) begin
               mode        = MODE_X_STEP;
               major_pos   = x1;
               major_stop  = x2;
               major_up    = x2 > x1;
               minor_pos   = y1;
               minor_up    = y2 > y1;
               major_delta = dx;
               minor_delta = dy;
               err         = dy - dx;
            end else begin
               mode        = MODE_Y_STEP;
               major_pos   = y1;
               major_stop  = y2;
               major_up    = y2 > y1;
               minor_pos   = x1;
               minor_up    = x2 > x1;
               major_delta = dy;
               minor_delta = dx;
               err         = dx - dy;
            end
            return 1;
         end

         // Ignore a tick while no line is active
         if (!active) return 0;

         y_major = (mode == MODE_Y_SPAN) || (mode == MODE_Y_STEP);
         stepped = (mode == MODE_X_STEP) || (mode == MODE_Y_STEP);
         p.x = y_major ? minor_pos : major_pos;
         p.y = y_major ? major_pos : minor_pos;
         nxt = major_up ? major_pos + 1'b1 : major_pos - 1'b1;
         p.last  = stepped ? (nxt == major_stop) : (major_pos == major_stop);
         ipx = p.x;
         ipy = p.y;
         p.vis   = (ipx > 0) && (ipy > 0) && (ipx < int'(canvas)) && (ipy < int'(canvas));
         p.color = held_color;
         expected_pixels.push_back(p);

         // Advance the walk
         if (p.last) begin
            active = 0;
         end else begin
            if (stepped) begin
               if (err >= 0) begin
                  minor_pos = minor_up ? minor_pos + 1'b1 : minor_pos - 1'b1;
                  err = err - $signed({2'b00, major_delta});
               end
               err = err + $signed({2'b00, minor_delta});
            end
            major_pos = nxt;
         end
         return 1;
      endfunction

      function void check_pixel(logic [RSP_W-1:0] data, logic tlast);
         pixel_rec e, g;
         g.x     = data[CB-1:0];
         g.y     = data[2*CB-1:CB];
         g.vis   = data[2*CB];
         g.color = data[2*CB+COLOR_BITS:2*CB+1];
         g.last  = tlast;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel x=%0d y=%0d vis=%0b color=%0d last=%0b",
                     $time, g.x, g.y, g.vis, g.color, g.last);
            return;
         end
         e = expected_pixels.pop_front();
         if (e.x !== g.x || e.y !== g.y || e.vis !== g.vis || e.color !== g.color ||
             e.last !== g.last) begin
            errors++;
            $display("%0t: pixel mismatch expected x=%0d y=%0d vis=%0b color=%0d last=%0b",
                     $time, e.x, e.y, e.vis, e.color, e.last);
            $display("%0t:                actual   x=%0d y=%0d vis=%0b color=%0d last=%0b",
                     $time, g.x, g.y, g.vis, g.color, g.last);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser = OP_TICK;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic                   rsp_tlast;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CANVAS_BITS-1:0] csr_data = '0;

   raster_scoreboard sb = new;
   int   active_items = 0;
   int   canvas_now = CANVAS_RESET;
   bit   quiet = 0;
   int   stall_left = 0;

   line_rasterizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result stream in random bursts, none in the quiet part
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watch all three handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
         if (csr_valid && csr_ready) sb.note_canvas(csr_data);
         if (req_tvalid && req_tready)
            if (sb.note_request(req_tuser, req_tdata)) active_items++;
      end
   end

   task automatic send_item(logic op, logic [REQ_W-1:0] data);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_line(int x1, int y1, int x2, int y2, int color);
      logic [REQ_W-1:0] d;
      d = '0;
      d[CB-1:0]      = CB'(x1);
      d[2*CB-1:CB]   = CB'(y1);
      d[3*CB-1:2*CB] = CB'(x2);
      d[4*CB-1:3*CB] = CB'(y2);
      d[4*CB+COLOR_BITS-1:4*CB] = COLOR_BITS'(color);
      send_item(OP_LOAD, d);
   endtask

   // Tick carries random payload bits, which the block must ignore
   task automatic tick();
      send_item(OP_TICK, REQ_W'({$urandom, $urandom}));
   endtask

   task automatic write_canvas(int v);
      csr_valid <= 1'b1;
      csr_data  <= CANVAS_BITS'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      canvas_now = v;
   endtask

   // Wait for every owed pixel, then wait out a tick still in flight
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int clamp_coord(int v);
      if (v < CMIN) return CMIN;
      if (v > CMAX) return CMAX;
      return v;
   endfunction

   // Bias coordinates around the canvas edges so visibility flips often
   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return clamp_coord(int'($urandom_range(0, canvas_now + 20)) - 10);
      if (r == 5) return $urandom_range(0, 1) ? CMAX : CMIN;
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   // Pixels a full line should emit: spans include both ends, stepped lines drop the end
   function automatic int line_pixels(int x1, int y1, int x2, int y2);
      int dx, dy;
      dx = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      if (dx == 0 || dy == 0) return ((dx > dy) ? dx : dy) + 1;
      return (dx > dy) ? dx : dy;
   endfunction

   // One line with random shape; mostly run to the end, sometimes cut or overrun
   task automatic draw_random();
      int x1, y1, x2, y2, kind, n, plan, r;
      x1 = pick_coord();
      y1 = pick_coord();
      kind = $urandom_range(0, 19);
      x2 = clamp_coord(x1 + int'($urandom_range(0, 24)) - 12);
      y2 = clamp_coord(y1 + int'($urandom_range(0, 24)) - 12);
      if (kind == 0) begin
         x2 = x1;
         y2 = y1;
      end else if (kind <= 2) begin
         y2 = y1;
      end else if (kind <= 4) begin
         x2 = x1;
      end else if (kind == 5) begin
         x2 = int'($urandom_range(0, 4095)) - 2048;
         y2 = int'($urandom_range(0, 4095)) - 2048;
      end
      load_line(x1, y1, x2, y2, $urandom_range(0, 3));
      n = line_pixels(x1, y1, x2, y2);
      plan = n;
      r = $urandom_range(0, 9);
      if (n > 48) plan = $urandom_range(1, 30);
      else if (r == 0) plan = $urandom_range(0, n - 1);
      else if (r == 1) plan = n + $urandom_range(1, 3);
      repeat (plan) tick();
   endtask

   task automatic random_phase(int count);
      int target;
      target = active_items + count;
      while (active_items < target) draw_random();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, point, reversed span, vertical span at the corner,
      // stepped line, extreme diagonal cut by a new load, y-major stepped line
      tick();
      load_line(5, 5, 5, 5, 1);
      tick();
      tick();
      load_line(7, 3, 3, 3, 2);
      repeat (5) tick();
      load_line(CMIN, CMAX, CMIN, CMAX - 2, 3);
      repeat (4) tick();
      load_line(0, 0, 4, 2, 0);
      repeat (4) tick();
      load_line(CMAX, CMIN, CMIN, CMAX, 3);
      repeat (2) tick();
      load_line(3, 1, 1, 6, 2);
      repeat (5) tick();
      drain_pixels();

      write_canvas(2047);
      random_phase(150);
      drain_pixels();
      write_canvas(2);
      random_phase(120);
      drain_pixels();
      write_canvas(0);
      random_phase(60);
      drain_pixels();
      write_canvas(1);
      random_phase(30);
      drain_pixels();

      // Last part runs back to back on both streams
      quiet = 1;
      write_canvas($urandom_range(2, 2047));
      random_phase(200);
      drain_pixels();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin
      #(20 * 400000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
